// ===== rtl/ksdlq_pkg.sv =====
// shared types and constants of the keyboard scan decoder with line queue
package ksdlq_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_SCAN = 2'd0,
        ACT_READ = 2'd1,
        ACT_MAP  = 2'd2
    } action_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COOK   = 3'd0,
        CFG_ECHO   = 3'd1,
        CFG_LSHIFT = 3'd2,
        CFG_LCTRL  = 3'd3,
        CFG_LALT   = 3'd4,
        CFG_ROFS   = 3'd5,
        CFG_CAPS   = 3'd6
    } cfg_index_t;

    // result kinds carried on m_tuser
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // stream widths
    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // line queue geometry
    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CHAR_W      = 7;

    // keymap geometry: plain, shifted and altgr rows
    localparam int MAP_ROW      = 132;
    localparam int MAP_SIZE     = 3 * MAP_ROW;
    localparam int MAP_COL_W    = $clog2(MAP_ROW);
    localparam int MAX_KEY_CODE = 383;

    // scan bytes
    localparam logic [7:0] BYTE_BREAK = 8'hF0;
    localparam logic [7:0] BYTE_EXT   = 8'hE0;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_BS  = 7'd8;
    localparam logic [CHAR_W-1:0] CHAR_NL  = 7'd10;
    localparam int                CHAR_MAX = 127;
    localparam int                ALPHA_LO = 97;
    localparam int                ALPHA_HI = 122;

    // modifier bit positions
    localparam int MOD_LSHIFT = 0;
    localparam int MOD_LCTRL  = 1;
    localparam int MOD_LALT   = 2;
    localparam int MOD_RSHIFT = 3;
    localparam int MOD_RCTRL  = 4;
    localparam int MOD_RALT   = 5;

endpackage

// ===== rtl/keyboard_scan_decoder_line_queue.sv =====
// keyboard scan decoder: keymap lookup, modifiers and line queue
//
// channel   dir  handshake          tuser            tdata (lowest bit up)
// s_        in   s_tvalid/s_tready  action[1:0]      scan_byte, map_index, map_word
// m_        out  m_tvalid/m_tready  kind[0]          char_value, queue_empty
// cfg_      in   cfg_wr_en          -                cfg_index selects, cfg_wdata
//
// one request per cycle unless m_ stalls; a request passes the decode stage register and then
// the result register before m_: the keymap and line queue memories both have registered reads
// reset clears flags, modifiers, pointers and config; memories stay as is
// a stalled m_ holds the decode stage, which then holds s_tready low
module keyboard_scan_decoder_line_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ksdlq_pkg::S_TUSER_W-1:0]     s_tuser,   // action
    input  logic [ksdlq_pkg::S_TDATA_W-1:0]     s_tdata,   // scan_byte, map_index, map_word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_tuser,   // kind
    output logic [ksdlq_pkg::M_TDATA_W-1:0]     m_tdata,   // char_value, queue_empty
    input  logic                                cfg_wr_en,
    input  logic [ksdlq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ksdlq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ksdlq_pkg::*;

    // request fields
    logic [1:0]  in_action;
    logic [7:0]  in_byte;
    logic [8:0]  in_index;
    logic [15:0] in_word;
    logic        s_accept;

    // configuration
    logic       cook_reg, echo_reg;
    logic [8:0] lshift_reg, lctrl_reg, lalt_reg, caps_key_reg;
    logic [6:0] rofs_reg;

    // decode stage
    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_fire, out_free;

    // keymap memories, one per row
    logic [15:0] km_row0_mem [MAP_ROW];
    logic [15:0] km_row1_mem [MAP_ROW];
    logic [15:0] km_row2_mem [MAP_ROW];
    logic [15:0] km0_reg, km1_reg, km2_reg;
    logic [MAP_COL_W-1:0] km_wcol;
    logic [1:0]  km_wrow;
    logic        km_we, km_re;

    // line queue memory
    logic [CHAR_W-1:0] q_mem [QUEUE_DEPTH];
    logic [CHAR_W-1:0] q_rdata_reg;
    logic              q_we;
    logic [CHAR_W-1:0] q_wdata;

    // decoder state
    logic             brk_reg, brk_next, ext_reg, ext_next, caps_reg, caps_next;
    logic [5:0]       mods_reg, mods_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next, cm_ptr_reg, cm_ptr_next;
    logic [PTR_W-1:0] ed_ptr_reg, ed_ptr_next, ed_inc, ed_dec, rd_inc;

    // result
    logic              res_valid, res_kind, res_empty;
    logic [CHAR_W-1:0] res_char;
    logic              m_tvalid_reg, m_kind_reg, m_empty_reg;
    logic [CHAR_W-1:0] m_char_reg;

    assign in_action = s_tuser;
    assign in_byte   = s_tdata[7:0];
    assign in_index  = s_tdata[16:8];
    assign in_word   = s_tdata[32:17];

    // handshakes
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cook_reg     <= 1'b1;
            echo_reg     <= 1'b1;
            lshift_reg   <= 9'd256;
            lctrl_reg    <= 9'd257;
            lalt_reg     <= 9'd258;
            rofs_reg     <= 7'd3;
            caps_key_reg <= 9'd262;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COOK:   cook_reg     <= cfg_wdata[0];
                CFG_ECHO:   echo_reg     <= cfg_wdata[0];
                CFG_LSHIFT: lshift_reg   <= cfg_wdata;
                CFG_LCTRL:  lctrl_reg    <= cfg_wdata;
                CFG_LALT:   lalt_reg     <= cfg_wdata;
                CFG_ROFS:   rofs_reg     <= cfg_wdata[6:0];
                CFG_CAPS:   caps_key_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // keymap write row and column from the flat index
    always_comb begin
        km_wrow = 2'd0;
        km_wcol = in_index[MAP_COL_W-1:0];
        if (in_index < 9'(MAP_ROW)) begin
            km_wrow = 2'd0;
            km_wcol = in_index[MAP_COL_W-1:0];
        end else if (in_index < 9'(2 * MAP_ROW)) begin
            km_wrow = 2'd1;
            km_wcol = MAP_COL_W'(in_index - 9'(MAP_ROW));
        end else begin
            km_wrow = 2'd2;
            km_wcol = MAP_COL_W'(in_index - 9'(2 * MAP_ROW));
        end
    end

    assign km_we = s_accept && (in_action == ACT_MAP) && (in_index < 9'(MAP_SIZE));
    assign km_re = s_accept && (in_action == ACT_SCAN) && (in_byte < 8'(MAP_ROW));

    // keymap access in request order: writes and lookups both at accept
    always_ff @(posedge aclk) begin
        if (km_we) begin
            case (km_wrow)
                2'd0:    km_row0_mem[km_wcol] <= in_word;
                2'd1:    km_row1_mem[km_wcol] <= in_word;
                default: km_row2_mem[km_wcol] <= in_word;
            endcase
        end
        if (km_re) begin
            km0_reg <= km_row0_mem[in_byte[MAP_COL_W-1:0]];
            km1_reg <= km_row1_mem[in_byte[MAP_COL_W-1:0]];
            km2_reg <= km_row2_mem[in_byte[MAP_COL_W-1:0]];
        end
    end

    // request register in front of the decode stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_action_reg <= in_action;
            s1_byte_reg   <= in_byte;
        end
    end

    // circular pointer steps
    assign ed_inc = (ed_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ed_ptr_reg + 1'b1;
    assign ed_dec = (ed_ptr_reg == '0) ? PTR_W'(QUEUE_DEPTH - 1) : ed_ptr_reg - 1'b1;
    assign rd_inc = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // decode stage: prefixes, modifiers, case rules and queue editing
    always_comb begin
        logic [16:0] val_base, val_adj, val_fin;
        logic [16:0] code_ls, code_lc, code_la, code_rs, code_rc, code_ra;
        logic        down, key_ok, shift, ctrl, alpha_case, is_alpha, use_shift_row;
        logic [CHAR_W-1:0] ch;

        val_base = {1'b0, km0_reg};
        code_ls  = {8'd0, lshift_reg};
        code_lc  = {8'd0, lctrl_reg};
        code_la  = {8'd0, lalt_reg};
        code_rs  = code_ls + {10'd0, rofs_reg};
        code_rc  = code_lc + {10'd0, rofs_reg};
        code_ra  = code_la + {10'd0, rofs_reg};

        // extended prefix moves a left modifier to its right-hand code
        if (ext_reg && (val_base == code_la || val_base == code_ls || val_base == code_lc)) begin
            val_adj = val_base + {10'd0, rofs_reg};
        end else begin
            val_adj = val_base;
        end

        down   = !brk_reg;
        key_ok = val_adj <= 17'(MAX_KEY_CODE);

        mods_next = mods_reg;
        if (key_ok && val_adj == code_ls) mods_next[MOD_LSHIFT] = down;
        if (key_ok && val_adj == code_lc) mods_next[MOD_LCTRL]  = down;
        if (key_ok && val_adj == code_la) mods_next[MOD_LALT]   = down;
        if (key_ok && val_adj == code_rs) mods_next[MOD_RSHIFT] = down;
        if (key_ok && val_adj == code_rc) mods_next[MOD_RCTRL]  = down;
        if (key_ok && val_adj == code_ra) mods_next[MOD_RALT]   = down;

        shift         = mods_next[MOD_LSHIFT] || mods_next[MOD_RSHIFT];
        ctrl          = mods_next[MOD_LCTRL] || mods_next[MOD_RCTRL];
        alpha_case    = shift != caps_reg;
        is_alpha      = val_adj >= 17'(ALPHA_LO) && val_adj <= 17'(ALPHA_HI);
        use_shift_row = ((alpha_case && is_alpha) || (shift && !is_alpha))
                        && val_adj < 17'(CHAR_MAX);

        // row selection
        if (use_shift_row) begin
            val_fin = {1'b0, km1_reg};
        end else if (mods_next[MOD_RALT]) begin
            val_fin = {1'b0, km2_reg};
        end else begin
            val_fin = val_adj;
        end

        // control folds into the low five bits
        ch = val_fin[CHAR_W-1:0];
        if (ctrl) begin
            ch = {2'b00, val_fin[4:0]};
        end

        brk_next    = brk_reg;
        ext_next    = ext_reg;
        caps_next   = caps_reg;
        rd_ptr_next = rd_ptr_reg;
        cm_ptr_next = cm_ptr_reg;
        ed_ptr_next = ed_ptr_reg;
        q_we        = 1'b0;
        q_wdata     = ch;
        res_valid   = 1'b0;
        res_kind    = KIND_ECHO;
        res_char    = ch;
        res_empty   = 1'b0;

        if (s1_fire) begin
            case (s1_action_reg)
                ACT_SCAN: begin
                    if (s1_byte_reg == BYTE_BREAK) begin
                        brk_next = 1'b1;
                    end else if (s1_byte_reg == BYTE_EXT) begin
                        ext_next = 1'b1;
                    end else if (s1_byte_reg < 8'(MAP_ROW)) begin
                        brk_next = 1'b0;
                        ext_next = 1'b0;
                        if (down) begin
                            if (val_adj == {8'd0, caps_key_reg}) begin
                                caps_next = !caps_reg;
                            end else if (val_fin != '0 && val_fin <= 17'(CHAR_MAX)) begin
                                if (ch == CHAR_BS && cook_reg) begin
                                    // erase one uncommitted character
                                    if (ed_ptr_reg != cm_ptr_reg) begin
                                        ed_ptr_next = ed_dec;
                                        res_valid   = echo_reg;
                                    end
                                end else begin
                                    q_we        = 1'b1;
                                    ed_ptr_next = ed_inc;
                                    res_valid   = echo_reg;
                                    if (ch == CHAR_NL || !cook_reg) begin
                                        cm_ptr_next = ed_inc;
                                    end
                                end
                            end
                        end
                    end else begin
                        mods_next = mods_reg;
                    end
                    if (s1_byte_reg == BYTE_BREAK || s1_byte_reg == BYTE_EXT) begin
                        mods_next = mods_reg;
                    end
                end
                ACT_READ: begin
                    mods_next = mods_reg;
                    res_valid = 1'b1;
                    res_kind  = KIND_READ;
                    if (rd_ptr_reg != cm_ptr_reg) begin
                        res_char    = q_rdata_reg;
                        rd_ptr_next = rd_inc;
                    end else begin
                        res_char  = '0;
                        res_empty = 1'b1;
                    end
                end
                default: begin
                    mods_next = mods_reg;
                end
            endcase
        end else begin
            mods_next = mods_reg;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brk_reg    <= 1'b0;
            ext_reg    <= 1'b0;
            caps_reg   <= 1'b0;
            mods_reg   <= '0;
            rd_ptr_reg <= '0;
            cm_ptr_reg <= '0;
            ed_ptr_reg <= '0;
        end else begin
            brk_reg    <= brk_next;
            ext_reg    <= ext_next;
            caps_reg   <= caps_next;
            mods_reg   <= mods_next;
            rd_ptr_reg <= rd_ptr_next;
            cm_ptr_reg <= cm_ptr_next;
            ed_ptr_reg <= ed_ptr_next;
        end
    end

    // line queue: write at the edit pointer, read data follows the read pointer
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[ed_ptr_reg] <= q_wdata;
        end
        if (q_we && ed_ptr_reg == rd_ptr_next) begin
            q_rdata_reg <= q_wdata;
        end else begin
            q_rdata_reg <= q_mem[rd_ptr_next];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_tvalid_reg <= res_valid;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && res_valid) begin
            m_kind_reg  <= res_kind;
            m_char_reg  <= res_char;
            m_empty_reg <= res_empty;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_empty_reg, m_char_reg};

endmodule

// ===== rtl/ksdlq_checker.sv =====
// port-level checks of the keyboard scan decoder, bound to the top level
module ksdlq_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [ksdlq_pkg::S_TUSER_W-1:0]     s_tuser,
    input logic [ksdlq_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic                                m_tuser,
    input logic [ksdlq_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                                cfg_wr_en,
    input logic [ksdlq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [ksdlq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ksdlq_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an echo never reports an empty queue
    a_echo_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ECHO |-> !m_tdata[7])
        else $error("echo flagged as empty");

    // an empty read answer carries a zero character
    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tuser == KIND_READ && m_tdata[6:0] == '0)
        else $error("empty answer malformed");

    // reset empties the result channel
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind keyboard_scan_decoder_line_queue ksdlq_checker u_ksdlq_checker (.*);
